/* src/psc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// psc_pkg
// Types, codes and constants shared by the pursuit steering controller.
// ---------------------------------------------------------------------------
package psc_pkg;

    localparam int CORDIC_STEPS = 22;
    localparam int APB_AW       = 5;

    localparam logic [4:0] CORDIC_LAST = 5'd21;
    localparam logic [4:0] SQRT_LAST   = 5'd31;
    localparam logic [4:0] DIV_LAST    = 5'd15;

    localparam logic signed [32:0] CORDIC_K = 33'sd652032874;

    // register indexes
    localparam logic [2:0] REG_SLOWDOWN_GAIN  = 3'd0;
    localparam logic [2:0] REG_ARRIVE_DIST    = 3'd1;
    localparam logic [2:0] REG_REVERSE_DOT    = 3'd2;
    localparam logic [2:0] REG_FORWARD_DOT    = 3'd3;
    localparam logic [2:0] REG_TURN_THRESHOLD = 3'd4;
    localparam logic [2:0] REG_ACCEL_SCALE    = 3'd5;
    localparam logic [2:0] REG_TURN_SCALE     = 3'd6;

    // reset values
    localparam logic [15:0]        RST_SLOWDOWN_GAIN  = 16'd200;
    localparam logic [30:0]        RST_ARRIVE_DIST    = 31'd655360;
    localparam logic signed [15:0] RST_REVERSE_DOT    = -16'sd26214;
    localparam logic signed [15:0] RST_FORWARD_DOT    = 16'sd16384;
    localparam logic [15:0]        RST_TURN_THRESHOLD = 16'd24576;
    localparam logic [15:0]        RST_ACCEL_SCALE    = 16'd32768;
    localparam logic [15:0]        RST_TURN_SCALE     = 16'd58982;

    typedef struct packed {
        logic [15:0]        slowdown_gain;
        logic [30:0]        arrive_distance;
        logic signed [15:0] reverse_dot;
        logic signed [15:0] forward_dot;
        logic [15:0]        turn_threshold;
        logic [15:0]        accel_scale;
        logic [15:0]        turn_scale;
    } t_cfg;

    typedef enum logic [4:0] {
        S_IDLE, S_NORM, S_VEC, S_BEAR, S_ERR, S_ROT, S_DOT, S_SQ_PRE, S_SQ_MUL1,
        S_SQ_ITER, S_DIST, S_DECIDE, S_ACHK, S_ADIV, S_ACUBE1, S_ACUBE2, S_ACUBE3,
        S_TCHK, S_TDIV, S_TCUBE1, S_TCUBE2, S_TCUBE3, S_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_NORM_R, OP_NORM_L, OP_VEC_INIT, OP_VEC, OP_BEAR, OP_ERR,
        OP_ROT, OP_DOT, OP_SQ_PRE, OP_SQ_MUL0, OP_SQ_MUL1, OP_SQ_ITER, OP_DIST,
        OP_DECIDE, OP_DIV_A, OP_DIV_T, OP_FULL_A, OP_FULL_T, OP_DIV, OP_CUBE1,
        OP_CUBE2, OP_CUBE3_A, OP_CUBE3_T, OP_OUT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [4:0] step;
    } t_cmd;

    typedef struct packed {
        logic zero;
        logic nrm_hi;
        logic nrm_lo;
        logic pre_big;
        logic arrived;
        logic a_go;
        logic t_go;
        logic out_busy;
    } t_stat;

    // arctangent of 2^-i in 1/2^24 turn
    function automatic logic [21:0] atan_lut(input logic [4:0] idx);
        logic [21:0] v;
        unique case (idx)
            5'd0:    v = 22'd2097152;
            5'd1:    v = 22'd1238021;
            5'd2:    v = 22'd654136;
            5'd3:    v = 22'd332050;
            5'd4:    v = 22'd166669;
            5'd5:    v = 22'd83416;
            5'd6:    v = 22'd41718;
            5'd7:    v = 22'd20860;
            5'd8:    v = 22'd10430;
            5'd9:    v = 22'd5215;
            5'd10:   v = 22'd2608;
            5'd11:   v = 22'd1304;
            5'd12:   v = 22'd652;
            5'd13:   v = 22'd326;
            5'd14:   v = 22'd163;
            5'd15:   v = 22'd81;
            5'd16:   v = 22'd41;
            5'd17:   v = 22'd20;
            5'd18:   v = 22'd10;
            5'd19:   v = 22'd5;
            5'd20:   v = 22'd3;
            5'd21:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* src/psc_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// psc_if
// Valid/ready channels: sensor samples in, steering commands out.
// ---------------------------------------------------------------------------
interface psc_sample_if #(
    parameter int COORD_BITS = 32,
    parameter int ANGLE_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] offset_x;
    logic signed [COORD_BITS-1:0] offset_y;
    logic        [ANGLE_BITS-1:0] heading;
    logic signed [COORD_BITS-1:0] speed;

    modport source (output valid, output offset_x, output offset_y, output heading,
                    output speed, input ready);
    modport sink   (input valid, input offset_x, input offset_y, input heading,
                    input speed, output ready);
endinterface

interface psc_cmd_if ();
    logic               valid;
    logic               ready;
    logic signed [15:0] throttle;
    logic signed [15:0] steer;
    logic               reversing;

    modport source (output valid, output throttle, output steer, output reversing,
                    input ready);
    modport sink   (input valid, input throttle, input steer, input reversing,
                    output ready);
endinterface
`default_nettype wire

/* src/psc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// psc_ctrl
// Sequencer: walks one sample through the shared datapath steps.
// ---------------------------------------------------------------------------
module psc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  psc_pkg::t_stat  i_stat,
    output psc_pkg::t_cmd   o_cmd
);
    import psc_pkg::*;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    t_op        w_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt + 5'd1;
        w_op       = OP_NOP;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    w_op    = OP_LOAD;
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                n_cnt = '0;
                priority if (i_stat.zero) begin
                    n_state = S_BEAR;
                end else if (i_stat.nrm_hi) begin
                    w_op = OP_NORM_R;
                end else if (i_stat.nrm_lo) begin
                    w_op = OP_NORM_L;
                end else begin
                    w_op    = OP_VEC_INIT;
                    n_state = S_VEC;
                end
            end
            S_VEC: begin
                w_op = OP_VEC;
                if (r_cnt == CORDIC_LAST) n_state = S_BEAR;
            end
            S_BEAR: begin
                w_op    = OP_BEAR;
                n_state = S_ERR;
            end
            S_ERR: begin
                w_op    = OP_ERR;
                n_cnt   = '0;
                n_state = S_ROT;
            end
            S_ROT: begin
                w_op = OP_ROT;
                if (r_cnt == CORDIC_LAST) n_state = S_DOT;
            end
            S_DOT: begin
                w_op    = OP_DOT;
                n_state = S_SQ_PRE;
            end
            S_SQ_PRE: begin
                if (i_stat.pre_big) begin
                    w_op = OP_SQ_PRE;
                end else begin
                    w_op    = OP_SQ_MUL0;
                    n_state = S_SQ_MUL1;
                end
            end
            S_SQ_MUL1: begin
                w_op    = OP_SQ_MUL1;
                n_cnt   = '0;
                n_state = S_SQ_ITER;
            end
            S_SQ_ITER: begin
                w_op = OP_SQ_ITER;
                if (r_cnt == SQRT_LAST) n_state = S_DIST;
            end
            S_DIST: begin
                w_op    = OP_DIST;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                w_op    = OP_DECIDE;
                n_state = S_ACHK;
            end
            S_ACHK: begin
                n_cnt = '0;
                priority if (i_stat.arrived) begin
                    n_state = S_OUT;
                end else if (i_stat.a_go) begin
                    w_op    = OP_DIV_A;
                    n_state = S_ADIV;
                end else begin
                    w_op    = OP_FULL_A;
                    n_state = S_TCHK;
                end
            end
            S_ADIV: begin
                w_op = OP_DIV;
                if (r_cnt == DIV_LAST) n_state = S_ACUBE1;
            end
            S_ACUBE1: begin
                w_op    = OP_CUBE1;
                n_state = S_ACUBE2;
            end
            S_ACUBE2: begin
                w_op    = OP_CUBE2;
                n_state = S_ACUBE3;
            end
            S_ACUBE3: begin
                w_op    = OP_CUBE3_A;
                n_state = S_TCHK;
            end
            S_TCHK: begin
                n_cnt = '0;
                if (i_stat.t_go) begin
                    w_op    = OP_DIV_T;
                    n_state = S_TDIV;
                end else begin
                    w_op    = OP_FULL_T;
                    n_state = S_OUT;
                end
            end
            S_TDIV: begin
                w_op = OP_DIV;
                if (r_cnt == DIV_LAST) n_state = S_TCUBE1;
            end
            S_TCUBE1: begin
                w_op    = OP_CUBE1;
                n_state = S_TCUBE2;
            end
            S_TCUBE2: begin
                w_op    = OP_CUBE2;
                n_state = S_TCUBE3;
            end
            S_TCUBE3: begin
                w_op    = OP_CUBE3_T;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    w_op    = OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd.op   = w_op;
    assign o_cmd.step = r_cnt;

endmodule
`default_nettype wire

/* src/psc_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// psc_dpath
// Shared CORDIC, square root, divider and cube multiplier, plus direction
// flag and output register.
// ---------------------------------------------------------------------------
module psc_dpath #(
    parameter int COORD_BITS = 32,
    parameter int ANGLE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  psc_pkg::t_cmd                i_cmd,
    output psc_pkg::t_stat               o_stat,
    input  psc_pkg::t_cfg                i_cfg,
    input  logic signed [COORD_BITS-1:0] i_offset_x,
    input  logic signed [COORD_BITS-1:0] i_offset_y,
    input  logic        [ANGLE_BITS-1:0] i_heading,
    input  logic signed [COORD_BITS-1:0] i_speed,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic signed [15:0]           o_throttle,
    output logic signed [15:0]           o_steer,
    output logic                         o_reversing
);
    import psc_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int A   = ANGLE_BITS;
    localparam int UW  = (C > 32) ? C : 32;
    localparam int DW  = C + 1;
    localparam int GVW = C + 15;
    localparam int DVW = C + 16;
    localparam int CW  = (DW > 31) ? DW : 31;
    localparam int SH  = 24 - A;
    localparam int SCW = $clog2(UW);
    localparam logic [24:0]  RND  = (SH > 0) ? 25'(1 << (SH - 1)) : 25'd0;
    localparam logic [A-1:0] HALF = {1'b1, {(A-1){1'b0}}};

    // sample
    logic signed [C-1:0] r_dx, r_dy, r_speed;
    logic [A-1:0]        r_head;
    // magnitudes for normalizing and root prescale
    logic [UW-1:0]       r_ua, r_ub;
    logic [SCW-1:0]      r_s;
    // CORDIC
    logic signed [32:0]  r_x, r_y;
    logic signed [24:0]  r_z;
    logic [A-1:0]        r_bear;
    logic [23:0]         r_abs24;
    logic                r_err_pos, r_neg;
    logic signed [15:0]  r_dot;
    // root
    logic [63:0]         r_sv, r_sr, r_sb;
    logic [DW-1:0]       r_dist;
    // decision and ratios
    logic                r_arrived, r_sp_ok, r_flag;
    logic [GVW-1:0]      r_gv;
    logic [DVW-1:0]      r_num, r_den;
    logic [15:0]         r_q, r_m;
    logic [16:0]         r_afac, r_tfac;
    // output
    logic                r_out_valid;
    logic signed [15:0]  r_throttle, r_steer;
    logic                r_reversing;

    logic [C-1:0]        w_iax, w_iay, w_rax, w_ray;
    logic [UW-1:0]       w_max;
    logic signed [32:0]  w_xs, w_ys;
    logic signed [24:0]  w_at;
    logic [22:0]         w_zc;
    logic [23:0]         w_z2, w_b24;
    logic [24:0]         w_bsum;
    logic [A-1:0]        w_diff, w_dabs;
    logic                w_epos;
    logic [23:0]         w_abs24, w_rota;
    logic signed [32:0]  w_xr, w_c;
    logic [15:0]         w_cl;
    logic [30:0]         w_mop;
    logic [61:0]         w_sq;
    logic [63:0]         w_rb;
    logic [DW+31:0]      w_dsh;
    logic                w_arr;
    logic [GVW-1:0]      w_gv;
    logic [DVW-1:0]      w_n2;
    logic [15:0]         w_pa, w_pb;
    logic [31:0]         w_prod, w_am, w_tm;
    logic [23:0]         w_thr24;

    assign w_iax = i_offset_x[C-1] ? C'(-i_offset_x) : C'(i_offset_x);
    assign w_iay = i_offset_y[C-1] ? C'(-i_offset_y) : C'(i_offset_y);
    assign w_rax = r_dx[C-1] ? C'(-r_dx) : C'(r_dx);
    assign w_ray = r_dy[C-1] ? C'(-r_dy) : C'(r_dy);
    assign w_max = (r_ua > r_ub) ? r_ua : r_ub;

    assign w_xs = r_x >>> i_cmd.step;
    assign w_ys = r_y >>> i_cmd.step;
    assign w_at = 25'(atan_lut(i_cmd.step));

    // fold the first-quadrant angle out to the sample's quadrant
    always_comb begin
        if (r_z < 0)                   w_zc = '0;
        else if (r_z > 25'sd4194304)   w_zc = 23'd4194304;
        else                           w_zc = r_z[22:0];
        w_z2  = r_dx[C-1] ? (24'h800000 - 24'(w_zc)) : 24'(w_zc);
        w_b24 = r_dy[C-1] ? (24'd0 - w_z2) : w_z2;
        if (r_ua == '0 && r_ub == '0) w_b24 = '0;
    end
    assign w_bsum = 25'(w_b24) + RND;

    // heading error wrapped to a half turn; exactly half counts positive
    always_comb begin
        w_diff = r_bear - r_head;
        if (w_diff > HALF) begin
            w_epos = 1'b0;
            w_dabs = A'(-w_diff);
        end else begin
            w_epos = (w_diff != '0);
            w_dabs = w_diff;
        end
        w_abs24 = 24'(w_dabs) << SH;
        w_rota  = (w_abs24 > 24'h400000) ? (24'h800000 - w_abs24) : w_abs24;
    end

    always_comb begin
        w_xr = r_x + 33'sd16384;
        w_c  = w_xr >>> 15;
        if (w_c < 0)                 w_cl = '0;
        else if (w_c > 33'sd32767)   w_cl = 16'd32767;
        else                         w_cl = w_c[15:0];
    end

    assign w_mop = (i_cmd.op == OP_SQ_MUL0) ? r_ua[30:0] : r_ub[30:0];
    assign w_sq  = w_mop * w_mop;
    assign w_rb  = r_sr + r_sb;
    assign w_dsh = {{DW{1'b0}}, r_sr[31:0]} << r_s;

    assign w_arr = !(CW'(r_dist) > CW'(i_cfg.arrive_distance));
    assign w_gv  = i_cfg.slowdown_gain * r_speed[C-2:0];
    assign w_n2  = r_num << 1;
    assign w_thr24 = {i_cfg.turn_threshold, 8'h00};

    always_comb begin
        w_pa = r_m;
        w_pb = r_q;
        unique case (i_cmd.op)
            OP_CUBE1:   w_pa = r_q;
            OP_CUBE3_A: w_pb = i_cfg.accel_scale;
            OP_CUBE3_T: w_pb = i_cfg.turn_scale;
            default:    w_pb = r_q;
        endcase
    end
    assign w_prod = w_pa * w_pb;

    // 32767 * factor as a shift and subtract
    assign w_am = {r_afac, 15'd0} - 32'(r_afac);
    assign w_tm = {r_tfac, 15'd0} - 32'(r_tfac);

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_dx    <= i_offset_x;
                r_dy    <= i_offset_y;
                r_head  <= i_heading;
                r_speed <= i_speed;
                r_ua    <= UW'(w_iax);
                r_ub    <= UW'(w_iay);
            end
            OP_NORM_R: begin
                r_ua <= r_ua >> 1;
                r_ub <= r_ub >> 1;
            end
            OP_NORM_L: begin
                r_ua <= r_ua << 1;
                r_ub <= r_ub << 1;
            end
            OP_VEC_INIT: begin
                r_x <= 33'(r_ua[29:0]);
                r_y <= 33'(r_ub[29:0]);
                r_z <= '0;
            end
            OP_VEC: begin
                // the iteration stops once y has reached zero
                if (r_y != 0) begin
                    if (!r_y[32]) begin
                        r_x <= r_x + w_ys;
                        r_y <= r_y - w_xs;
                        r_z <= r_z + w_at;
                    end else begin
                        r_x <= r_x - w_ys;
                        r_y <= r_y + w_xs;
                        r_z <= r_z - w_at;
                    end
                end
            end
            OP_BEAR: r_bear <= A'(w_bsum >> SH);
            OP_ERR: begin
                r_abs24   <= w_abs24;
                r_err_pos <= w_epos;
                r_neg     <= (w_abs24 > 24'h400000);
                r_x       <= CORDIC_K;
                r_y       <= '0;
                r_z       <= 25'(w_rota);
            end
            OP_ROT: begin
                if (!r_z[24]) begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_at;
                end else begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_at;
                end
            end
            OP_DOT: begin
                r_dot <= r_neg ? -$signed(w_cl) : $signed(w_cl);
                r_ua  <= UW'(w_rax);
                r_ub  <= UW'(w_ray);
                r_s   <= '0;
            end
            OP_SQ_PRE: begin
                r_ua <= r_ua >> 1;
                r_ub <= r_ub >> 1;
                r_s  <= r_s + 1'b1;
            end
            OP_SQ_MUL0: r_sv <= 64'(w_sq);
            OP_SQ_MUL1: begin
                r_sv <= r_sv + 64'(w_sq);
                r_sr <= '0;
                r_sb <= 64'h4000_0000_0000_0000;
            end
            OP_SQ_ITER: begin
                if (r_sv >= w_rb) begin
                    r_sv <= r_sv - w_rb;
                    r_sr <= (r_sr >> 1) + r_sb;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sb <= r_sb >> 2;
            end
            OP_DIST: r_dist <= DW'(w_dsh);
            OP_DECIDE: begin
                r_gv    <= w_gv;
                r_sp_ok <= !r_speed[C-1] && (r_speed != 0) && (i_cfg.slowdown_gain != '0);
            end
            OP_DIV_A: begin
                r_num <= DVW'(r_dist);
                r_den <= DVW'(r_gv);
                r_q   <= '0;
            end
            OP_DIV_T: begin
                r_num <= DVW'(r_abs24);
                r_den <= DVW'(w_thr24);
                r_q   <= '0;
            end
            OP_DIV: begin
                if (w_n2 >= r_den) begin
                    r_num <= w_n2 - r_den;
                    r_q   <= {r_q[14:0], 1'b1};
                end else begin
                    r_num <= w_n2;
                    r_q   <= {r_q[14:0], 1'b0};
                end
            end
            OP_FULL_A:  r_afac <= 17'h10000;
            OP_FULL_T:  r_tfac <= 17'h10000;
            OP_CUBE1:   r_m <= w_prod[31:16];
            OP_CUBE2:   r_m <= w_prod[31:16];
            OP_CUBE3_A: r_afac <= {1'b0, w_prod[31:16]};
            OP_CUBE3_T: r_tfac <= {1'b0, w_prod[31:16]};
            OP_OUT: begin
                // flag is captured with the beat; the next sample may move it
                r_reversing <= r_flag;
                if (r_arrived) begin
                    r_throttle <= '0;
                    r_steer    <= '0;
                end else begin
                    r_throttle <= r_flag ? -$signed(w_am[31:16]) : $signed(w_am[31:16]);
                    r_steer    <= (r_flag != r_err_pos) ? $signed(w_tm[31:16])
                                                        : -$signed(w_tm[31:16]);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag      <= 1'b0;
            r_arrived   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_DECIDE) begin
                r_arrived <= w_arr;
                // hysteresis on alignment; flag holds on arrival
                if (!w_arr) begin
                    if (!r_flag && (r_dot < i_cfg.reverse_dot)) r_flag <= 1'b1;
                    else if (r_flag && (r_dot > i_cfg.forward_dot)) r_flag <= 1'b0;
                end
            end
            if (i_cmd.op == OP_OUT) r_out_valid <= 1'b1;
            else if (i_out_ready)   r_out_valid <= 1'b0;
        end
    end

    assign o_stat.zero     = (r_ua == '0) && (r_ub == '0);
    assign o_stat.nrm_hi   = |w_max[UW-1:30];
    assign o_stat.nrm_lo   = ~|w_max[UW-1:29];
    assign o_stat.pre_big  = |w_max[UW-1:31];
    assign o_stat.arrived  = r_arrived;
    assign o_stat.a_go     = r_sp_ok && (GVW'(r_dist) < r_gv);
    assign o_stat.t_go     = r_abs24 < w_thr24;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_throttle  = r_throttle;
    assign o_steer     = r_steer;
    assign o_reversing = r_reversing;

endmodule
`default_nettype wire

/* src/pursuit_steering_controller.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pursuit_steering_controller
// Bearing, distance and alignment to a target give throttle, steer and a
// forward/reverse flag; APB register file for the tuning values.
// ---------------------------------------------------------------------------
//  port      dir  kind          beat payload
//  i_sample  in   valid/ready   offset_x, offset_y, heading, speed
//  o_cmd     out  valid/ready   throttle, steer, reversing
//  psel..    in   APB slave     7 registers at 4*i
//
//  One sample at a time. Each beat runs bearing normalize (1 bit/cycle),
//  22 vectoring + 22 rotation CORDIC steps, root prescale (up to
//  COORD_BITS-31) + 32 root steps, and two 16-step divides with 3 cube
//  multiplies each when they apply. A zero offset skips vectoring and
//  always arrives.
//  Synchronous active-low reset clears the sequencer, flag and output valid.
//  A finished result waits in the output register; a new sample is taken
//  while it waits, and the next result waits until it has drained.
// ---------------------------------------------------------------------------
module pursuit_steering_controller #(
    parameter int COORD_BITS = 32,
    parameter int ANGLE_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    psc_sample_if.sink                  i_sample,
    psc_cmd_if.source                   o_cmd,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [psc_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import psc_pkg::*;

    t_cfg       r_cfg;
    t_cmd       w_cmd;
    t_stat      w_stat;
    logic       w_in_ready;
    logic [2:0] w_idx;

    assign w_idx  = paddr[APB_AW-1:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slowdown_gain   <= RST_SLOWDOWN_GAIN;
            r_cfg.arrive_distance <= RST_ARRIVE_DIST;
            r_cfg.reverse_dot     <= RST_REVERSE_DOT;
            r_cfg.forward_dot     <= RST_FORWARD_DOT;
            r_cfg.turn_threshold  <= RST_TURN_THRESHOLD;
            r_cfg.accel_scale     <= RST_ACCEL_SCALE;
            r_cfg.turn_scale      <= RST_TURN_SCALE;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_SLOWDOWN_GAIN:  r_cfg.slowdown_gain   <= pwdata[15:0];
                REG_ARRIVE_DIST:    r_cfg.arrive_distance <= pwdata[30:0];
                REG_REVERSE_DOT:    r_cfg.reverse_dot     <= pwdata[15:0];
                REG_FORWARD_DOT:    r_cfg.forward_dot     <= pwdata[15:0];
                REG_TURN_THRESHOLD: r_cfg.turn_threshold  <= pwdata[15:0];
                REG_ACCEL_SCALE:    r_cfg.accel_scale     <= pwdata[15:0];
                REG_TURN_SCALE:     r_cfg.turn_scale      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_SLOWDOWN_GAIN:  prdata = 32'(r_cfg.slowdown_gain);
            REG_ARRIVE_DIST:    prdata = 32'(r_cfg.arrive_distance);
            REG_REVERSE_DOT:    prdata = 32'(r_cfg.reverse_dot);
            REG_FORWARD_DOT:    prdata = 32'(r_cfg.forward_dot);
            REG_TURN_THRESHOLD: prdata = 32'(r_cfg.turn_threshold);
            REG_ACCEL_SCALE:    prdata = 32'(r_cfg.accel_scale);
            REG_TURN_SCALE:     prdata = 32'(r_cfg.turn_scale);
            default:            prdata = '0;
        endcase
    end

    psc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    psc_dpath #(
        .COORD_BITS (COORD_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg       (r_cfg),
        .i_offset_x  (i_sample.offset_x),
        .i_offset_y  (i_sample.offset_y),
        .i_heading   (i_sample.heading),
        .i_speed     (i_sample.speed),
        .i_out_ready (o_cmd.ready),
        .o_out_valid (o_cmd.valid),
        .o_throttle  (o_cmd.throttle),
        .o_steer     (o_cmd.steer),
        .o_reversing (o_cmd.reversing)
    );

    assign i_sample.ready = w_in_ready;

endmodule
`default_nettype wire
